// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the circle rasteriser RTL.
// Both macros compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hdl/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Midpoint circle rasteriser package
// Shared widths, codes and transaction types for the rasteriser modules.
// ----------------------------------------------------------------------------
package mcr_pkg;

    // Coordinate width of the centre and radius fields.
    localparam int COORD_BITS = 10;
    // Signed octant offsets need one more bit, pixels two more.
    localparam int STEP_BITS  = COORD_BITS + 1;
    localparam int PIX_BITS   = COORD_BITS + 2;
    // The decision variable stays within this many bits, signed.
    localparam int DEC_BITS   = COORD_BITS + 4;

    // Pixels emitted per octet and the index counter that walks them.
    localparam int OCTET_PIXELS = 8;
    localparam int IDX_BITS     = $clog2(OCTET_PIXELS);

    // Octet queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Item function codes.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    typedef logic        [COORD_BITS-1:0] t_coord;
    typedef logic signed [STEP_BITS-1:0]  t_step;
    typedef logic signed [DEC_BITS-1:0]   t_dec;
    typedef logic signed [PIX_BITS-1:0]   t_pix;

    // Input transaction.
    typedef struct packed {
        logic   func;
        t_coord center_x;
        t_coord center_y;
        t_coord radius;
    } t_in_item;

    // Result transaction.
    typedef struct packed {
        t_pix pixel_x;
        t_pix pixel_y;
        logic last_of_octet;
        logic circle_done;
    } t_out_item;

    // One octet to be plotted: centre, offsets and the final flag.
    typedef struct packed {
        t_coord cx;
        t_coord cy;
        t_step  x;
        t_step  y;
        logic   done;
    } t_octet;

endpackage

// ===== hdl/midpoint_circle_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// Midpoint circle rasteriser, top level
// An item's pixels pass through the octet queue, the descriptor register
// and the single result register, one pixel per cycle while results are
// popped; the front end takes items back to back until the two-entry
// octet queue fills. Steps while idle are accepted and emit nothing.
// Reset is synchronous and active low: idle, queue and results empty.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  mcr_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output mcr_pkg::t_out_item o_item
);
    import mcr_pkg::*;

    logic   q_push, q_full, q_pop, q_empty;
    t_octet q_in, q_out;

    // Item acceptance and decision update.
    mcr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .o_q_push  (q_push),
        .o_q_octet (q_in),
        .i_q_full  (q_full)
    );

    // Octet descriptors waiting for the pixel stage.
    mcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_octet (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_octet (q_out)
    );

    // Pixel generation and result register.
    mcr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_octet (q_out),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_item    (o_item)
    );

endmodule

// ===== hdl/mcr_front.sv =====
// ----------------------------------------------------------------------------
// Rasteriser front end
// Accepts start and step items, runs the midpoint decision update and
// hands one octet descriptor per emitting item to the octet queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  mcr_pkg::t_in_item i_item,
    output logic              o_q_push,
    output mcr_pkg::t_octet   o_q_octet,
    input  logic              i_q_full
);
    import mcr_pkg::*;

    localparam t_dec DEC_INIT       = t_dec'(3);
    localparam t_dec DEC_STEP_PLAIN = t_dec'(6);
    localparam t_dec DEC_STEP_DIAG  = t_dec'(10);
    localparam t_step STEP_ONE      = t_step'(1);

    t_coord r_cx, r_cy;
    t_step  r_x, r_y;
    t_dec   r_dec;
    logic   r_active;

    t_coord n_cx, n_cy;
    t_step  n_x, n_y;
    t_dec   n_dec;
    logic   n_active;

    logic accept;
    logic is_start;
    logic emit;
    logic done;

    assign full     = i_q_full;
    assign accept   = push && !i_q_full;
    assign is_start = (i_item.func == FUNC_START);
    assign emit     = accept && (is_start || r_active);

    // Decision update and next octant position.
    always_comb begin
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_x      = r_x;
        n_y      = r_y;
        n_dec    = r_dec;
        n_active = r_active;
        done     = 1'b0;
        if (is_start) begin
            n_cx     = i_item.center_x;
            n_cy     = i_item.center_y;
            n_x      = '0;
            n_y      = t_step'(i_item.radius);
            n_dec    = DEC_INIT - (t_dec'(i_item.radius) <<< 1);
            n_active = 1'b1;
        end else begin
            if (r_dec <= 0) begin
                n_dec = r_dec + (t_dec'(r_x) <<< 2) + DEC_STEP_PLAIN;
            end else begin
                n_dec = r_dec + (t_dec'(r_x - r_y) <<< 2) + DEC_STEP_DIAG;
                n_y   = r_y - STEP_ONE;
            end
            n_x  = r_x + STEP_ONE;
            done = (n_x > n_y);
            if (done) begin
                n_active = 1'b0;
            end
        end
    end

    // State is only touched by items that emit an octet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_dec    <= '0;
            r_active <= 1'b0;
        end else if (emit) begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_x      <= n_x;
            r_y      <= n_y;
            r_dec    <= n_dec;
            r_active <= n_active;
        end
    end

    // The descriptor carries the position after the update.
    assign o_q_push       = emit;
    assign o_q_octet.cx   = n_cx;
    assign o_q_octet.cy   = n_cy;
    assign o_q_octet.x    = n_x;
    assign o_q_octet.y    = n_y;
    assign o_q_octet.done = done;

    `ASSERT_IMPL(a_step_needs_active, i_clk, i_rst_n, o_q_push && !is_start, r_active, "step octet emitted while idle")

endmodule

// ===== hdl/mcr_queue.sv =====
// ----------------------------------------------------------------------------
// Octet queue
// Short first-in first-out buffer of octet descriptors between the
// front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mcr_pkg::t_octet i_octet,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output mcr_pkg::t_octet o_octet
);
    import mcr_pkg::*;

    localparam logic [QCNT_BITS-1:0] QCNT_FULL = QCNT_BITS'(QUEUE_DEPTH);
    localparam logic [QPTR_BITS-1:0] QPTR_LAST = QPTR_BITS'(QUEUE_DEPTH - 1);

    t_octet                r_entry [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_BITS-1:0]  r_count;
    logic                  do_push, do_pop;

    assign o_full  = (r_count == QCNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_octet = r_entry[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_octet;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_FULL, "queue count overflow")
    `ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "octet pushed into a full queue")

endmodule

// ===== hdl/mcr_back.sv =====
// ----------------------------------------------------------------------------
// Rasteriser back end
// Expands each octet descriptor into eight mirrored pixels, one per cycle
// while the result is free or popped, through a registered result stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  mcr_pkg::t_octet    i_q_octet,
    output logic               o_q_pop,
    output logic               empty,
    input  logic               pop,
    output mcr_pkg::t_out_item o_item
);
    import mcr_pkg::*;

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(OCTET_PIXELS - 1);

    t_octet               r_oct;
    logic                 r_busy;
    logic [IDX_BITS-1:0]  r_idx;
    t_out_item            r_out;
    logic                 r_out_valid;

    logic      out_free, advance, last, take;
    t_pix      cx, cy, ox, oy;
    t_out_item n_out;

    assign out_free = !r_out_valid || pop;
    assign advance  = r_busy && out_free;
    assign last     = (r_idx == LAST_IDX);
    assign take     = !i_q_empty && (!r_busy || (advance && last));
    assign o_q_pop  = take;

    // Mirror the octant offsets about the centre in plotting order.
    always_comb begin
        cx = t_pix'(r_oct.cx);
        cy = t_pix'(r_oct.cy);
        ox = t_pix'(r_oct.x);
        oy = t_pix'(r_oct.y);
        n_out.last_of_octet = last;
        n_out.circle_done   = r_oct.done;
        unique case (r_idx)
            3'd0: begin
                n_out.pixel_x = cx + ox;
                n_out.pixel_y = cy + oy;
            end
            3'd1: begin
                n_out.pixel_x = cx + ox;
                n_out.pixel_y = cy - oy;
            end
            3'd2: begin
                n_out.pixel_x = cx - ox;
                n_out.pixel_y = cy - oy;
            end
            3'd3: begin
                n_out.pixel_x = cx - ox;
                n_out.pixel_y = cy + oy;
            end
            3'd4: begin
                n_out.pixel_x = cx + oy;
                n_out.pixel_y = cy + ox;
            end
            3'd5: begin
                n_out.pixel_x = cx + oy;
                n_out.pixel_y = cy - ox;
            end
            3'd6: begin
                n_out.pixel_x = cx - oy;
                n_out.pixel_y = cy - ox;
            end
            default: begin
                n_out.pixel_x = cx - oy;
                n_out.pixel_y = cy + ox;
            end
        endcase
    end

    // Current descriptor and pixel index.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_oct <= i_q_octet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
            end else if (advance && last) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_idx <= last ? '0 : r_idx + 1'b1;
            end
        end
    end

    // Result register, refilled when busy and empty or being popped.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign empty  = !r_out_valid;
    assign o_item = r_out;

    `ASSERT_IMPL(a_idle_idx_zero, i_clk, i_rst_n, !r_busy, r_idx == '0, "pixel index moved while idle")

endmodule

// ===== test/tb_midpoint_circle_rasterizer_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Midpoint circle rasteriser testbench
// Drives start and step transactions through the push port and predicts
// every plotted pixel: centre, octant offsets, decision updates and the final
// octet flag. Both sides idle at random, the result side holds off once for a
// long stretch so the input stalls, and every pixel is checked field by field.
// ----------------------------------------------------------------------------
module tb_midpoint_circle_rasterizer_top;

    import mcr_pkg::*;

    localparam int RANDOM_ITEMS   = 155;
    localparam int MAX_GAP        = 19;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_PIXEL  = 400;
    localparam int DRAIN_CYCLES   = 16;
    // Longest quiet stretch in a correct run comes from the long hold.
    localparam int WATCHDOG_LIMIT = 2000;

    // Tracks the circle being drawn and the pixels still owed by the block.
    class circle_scoreboard;
        t_coord    hold_cx;
        t_coord    hold_cy;
        t_step     col;
        t_step     row;
        t_dec      dec;
        bit        drawing;
        int        errors;
        t_out_item expected_pixels[$];

        function new();
            hold_cx = '0;
            hold_cy = '0;
            col     = '0;
            row     = '0;
            dec     = '0;
            drawing = 1'b0;
            errors  = 0;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Queue the eight symmetric pixels of the current offsets.
        function void plot_octet(bit done);
            int        px[8];
            int        py[8];
            int        cx;
            int        cy;
            int        x;
            int        y;
            t_out_item p;
            cx = int'(hold_cx);
            cy = int'(hold_cy);
            x  = int'(col);
            y  = int'(row);
            px = '{cx + x, cx + x, cx - x, cx - x, cx + y, cx + y, cx - y, cx - y};
            py = '{cy + y, cy - y, cy - y, cy + y, cy + x, cy - x, cy - x, cy + x};
            for (int k = 0; k < OCTET_PIXELS; k++) begin
                p.pixel_x       = t_pix'(px[k]);
                p.pixel_y       = t_pix'(py[k]);
                p.last_of_octet = (k == OCTET_PIXELS - 1);
                p.circle_done   = done;
                expected_pixels.push_back(p);
            end
        endfunction

        // Apply one accepted transaction; returns the number of pixels it owes.
        function int note_item(t_in_item it);
            int next_dec;
            bit done;
            if (it.func == FUNC_START) begin
                hold_cx = it.center_x;
                hold_cy = it.center_y;
                col     = '0;
                row     = t_step'(int'(it.radius));
                dec     = t_dec'(3 - 2 * int'(it.radius));
                drawing = 1'b1;
                plot_octet(1'b0);
                return OCTET_PIXELS;
            end
            // A step with no circle in progress is ignored.
            if (!drawing) begin
                return 0;
            end
            if (dec <= 0) begin
                next_dec = int'(dec) + 4 * int'(col) + 6;
            end else begin
                next_dec = int'(dec) + 4 * int'(col) - 4 * int'(row) + 10;
                row      = row - t_step'(1);
            end
            dec     = t_dec'(next_dec);
            col     = col + t_step'(1);
            done    = (col > row);
            drawing = !done;
            plot_octet(done);
            return OCTET_PIXELS;
        endfunction

        function void match_field(string name, t_pix want, t_pix got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one popped pixel with the oldest expectation.
        function void check_pixel(t_out_item got);
            t_out_item want;
            if (expected_pixels.size() == 0) begin
                $display("%0t: pixel with none expected, expected nothing, got x=%0d y=%0d",
                         $time, got.pixel_x, got.pixel_y);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            match_field("pixel_x", want.pixel_x, got.pixel_x);
            match_field("pixel_y", want.pixel_y, got.pixel_y);
            match_field("last_of_octet", t_pix'(want.last_of_octet), t_pix'(got.last_of_octet));
            match_field("circle_done", t_pix'(want.circle_done), t_pix'(got.circle_done));
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      full;
    t_in_item  i_item  = '0;
    logic      empty;
    logic      pop     = 1'b0;
    t_out_item o_item;

    circle_scoreboard sb = new();
    bit tx_burst    = 1'b0;
    int octets_sent = 0;

    midpoint_circle_rasterizer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // A step transaction; the coordinate fields carry noise the block must ignore.
    function automatic t_in_item step_item();
        t_in_item s;
        s.func     = FUNC_STEP;
        s.center_x = t_coord'($urandom_range(0, 1023));
        s.center_y = t_coord'($urandom_range(0, 1023));
        s.radius   = t_coord'($urandom_range(0, 1023));
        return s;
    endfunction

    // Offer one transaction after a random gap and wait until it is taken.
    task automatic send_item(input t_in_item it);
        int gap;
        if ($urandom_range(0, 15) == 0) begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        if (sb.note_item(it) > 0) begin
            octets_sent++;
        end
    endtask

    // Start a circle and step it until it finishes or max_steps have been sent.
    task automatic run_circle(input t_coord cx, input t_coord cy, input t_coord r,
                              input int max_steps);
        t_in_item it;
        int       n;
        it.func     = FUNC_START;
        it.center_x = cx;
        it.center_y = cy;
        it.radius   = r;
        send_item(it);
        n = 0;
        while (sb.drawing && n < max_steps) begin
            send_item(step_item());
            n++;
        end
    endtask

    // Stimulus and end of run.
    initial begin
        int     first_random;
        int     pick;
        t_coord cx;
        t_coord cy;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: idle steps, zero and full radius, restart mid-circle,
        // and the smallest radii run to completion.
        send_item(step_item());
        run_circle(10'd0, 10'd0, 10'd0, 100);
        send_item(step_item());
        run_circle(10'd1023, 10'd1023, 10'd1023, 3);
        run_circle(10'd0, 10'd0, 10'd1023, 3);
        run_circle(10'd512, 10'd341, 10'd1, 100);
        run_circle(10'd685, 10'd170, 10'd2, 100);
        run_circle(10'd300, 10'd700, 10'd3, 100);

        // Let the block drain completely before the random part.
        push <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);

        // Random part: mostly whole small circles, some abandoned ones,
        // some large radii cut short, and stray steps.
        first_random = octets_sent;
        while (octets_sent - first_random < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            cx   = t_coord'($urandom_range(0, 1023));
            cy   = t_coord'($urandom_range(0, 1023));
            if (pick < 14) begin
                run_circle(cx, cy, t_coord'($urandom_range(0, 24)), 1000);
            end else if (pick < 16) begin
                run_circle(cx, cy, t_coord'($urandom_range(25, 1023)),
                           $urandom_range(1, 12));
            end else if (pick < 18) begin
                run_circle(cx, cy, t_coord'($urandom_range(0, 24)), $urandom_range(0, 6));
            end else begin
                send_item(step_item());
            end
        end

        push <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_midpoint_circle_rasterizer_top: done, clean");
        end else begin
            $display("tb_midpoint_circle_rasterizer_top: done, errors");
        end
        $finish;
    end

    // Result side: random pop gaps, and one long hold so the input backs up.
    initial begin
        int gap;
        int seen;
        bit burst;
        seen  = 0;
        burst = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                burst = !burst;
            end
            if (seen == HOLD_AT_PIXEL) begin
                gap = LONG_HOLD;
            end else begin
                gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_pixel(o_item);
            seen++;
        end
    end

    // Watchdog: ends the run if no transaction moves on either side for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (!i_rst_n) @(posedge i_clk);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_midpoint_circle_rasterizer_top: done, errors");
        $finish;
    end

endmodule

// ===== midpoint_circle_rasterizer_top.f =====
+incdir+hdl
hdl/mcr_pkg.sv
hdl/mcr_front.sv
hdl/mcr_queue.sv
hdl/mcr_back.sv
hdl/midpoint_circle_rasterizer_top.sv
test/tb_midpoint_circle_rasterizer_top.sv
